// File: sv/tbd_pkg.sv
// Shared types, screen-layout constants and helpers for the touch button decoder.
// No dependencies; used by the interfaces, the hit tester and the top level.
package tbd_pkg;

  // Field widths
  localparam int unsigned CmdW      = 2;
  localparam int unsigned CoordW    = 9;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned TimeoutW  = 16;
  localparam int unsigned StepW     = 7;
  localparam int unsigned UdW       = 8;
  localparam int unsigned LrW       = 2;
  localparam int unsigned KeyW      = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  // Grid of sections
  localparam int unsigned MaxSections     = 16;
  localparam int unsigned GridSectionsDef = 16;
  localparam int unsigned GridCols        = 4;
  localparam int unsigned SectW           = $clog2(MaxSections);

  // Screen layout
  localparam int unsigned ScreenMaxX = 319;
  localparam int unsigned ScreenMaxY = 239;
  localparam int unsigned BarSize    = 20;
  localparam int unsigned Gap        = 5;
  localparam int unsigned HeaderH    = 17;
  localparam int unsigned CellW      = 75;
  localparam int unsigned CellH      = 45;
  localparam int unsigned GridTop    = 30;
  localparam int unsigned PanelW     = CellW * GridCols - Gap;

  localparam int unsigned UdXLo    = PanelW + Gap;
  localparam int unsigned UdXHi    = ScreenMaxX;
  localparam int unsigned UdYLo    = HeaderH;
  localparam int unsigned UdYHi    = ScreenMaxY;
  localparam int unsigned UpYHi    = HeaderH + BarSize;
  localparam int unsigned DownYLo  = ScreenMaxY - BarSize;
  localparam int unsigned LrXHi    = PanelW;
  localparam int unsigned LrYHi    = HeaderH;
  localparam int unsigned LeftXHi  = BarSize - Gap;
  localparam int unsigned RightXLo = PanelW - BarSize + Gap;
  localparam int unsigned CellSpanX = CellW - Gap;
  localparam int unsigned CellSpanY = CellH - Gap;

  // Register reset values
  localparam logic [TimeoutW-1:0] RepeatTimeoutRst = TimeoutW'(250);
  localparam logic [TimeoutW-1:0] AccelTimeoutRst  = TimeoutW'(1000);
  localparam logic [StepW-1:0]    AccelStepRst     = StepW'(10);

  typedef enum logic [CmdW-1:0] {
    CmdPoll    = 2'd0,
    CmdReadLr  = 2'd1,
    CmdReadKey = 2'd2,
    CmdUnused  = 2'd3
  } command_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegRepeatTimeout = 2'd0,
    RegAccelTimeout  = 2'd1,
    RegAccelStep     = 2'd2,
    RegReserved      = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    BtnUp      = 3'd0,
    BtnDown    = 3'd1,
    BtnLeft    = 3'd2,
    BtnRight   = 3'd3,
    BtnSection = 3'd4,
    BtnNone    = 3'd5
  } button_e;

  // Outcome of one hit test
  typedef struct packed {
    button_e          button;
    logic [SectW-1:0] section;
  } hit_t;

  function automatic logic [CoordW-1:0] cell_x_lo(int unsigned idx);
    return CoordW'((idx % GridCols) * CellW);
  endfunction

  function automatic logic [CoordW-1:0] cell_y_lo(int unsigned idx);
    return CoordW'(GridTop + (idx / GridCols) * CellH);
  endfunction

endpackage

// File: sv/tbd_if.sv
// Valid/ready channel interfaces for poll/read items and result items.
// Depends on tbd_pkg for field widths.
interface tbd_in_if;
  logic                         valid;
  logic                         ready;
  logic [tbd_pkg::CmdW-1:0]     command;
  logic [tbd_pkg::CoordW-1:0]   touch_x;
  logic [tbd_pkg::CoordW-1:0]   touch_y;
  logic                         touch_pressed;
  logic [tbd_pkg::TimeW-1:0]    now_ms;

  modport source (output valid, command, touch_x, touch_y, touch_pressed, now_ms,
                  input ready);
  modport sink   (input valid, command, touch_x, touch_y, touch_pressed, now_ms,
                  output ready);
endinterface

interface tbd_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [tbd_pkg::UdW-1:0]  updown_step;
  logic signed [tbd_pkg::LrW-1:0]  leftright_step;
  logic signed [tbd_pkg::KeyW-1:0] key_index;

  modport source (output valid, updown_step, leftright_step, key_index, input ready);
  modport sink   (input valid, updown_step, leftright_step, key_index, output ready);
endinterface

// File: sv/tbd_hit_test.sv
// Hit test of one touch sample against the up/down bar, the left/right bar and the grid.
// Depends on tbd_pkg for layout constants and the hit_t result type.
module tbd_hit_test #(
  parameter int unsigned GridSections = tbd_pkg::GridSectionsDef
) (
  input  logic [tbd_pkg::CoordW-1:0] touch_x_i,
  input  logic [tbd_pkg::CoordW-1:0] touch_y_i,
  input  logic                       touch_pressed_i,
  output tbd_pkg::hit_t              hit_o
);

  localparam int unsigned W = tbd_pkg::CoordW;

  logic                          in_ud_bar, in_lr_bar, in_up, in_down, in_left, in_right;
  logic [GridSections-1:0]       cell_hit;
  logic                          any_cell;
  logic [tbd_pkg::SectW-1:0]     cell_idx;

  assign in_ud_bar = touch_x_i >= W'(tbd_pkg::UdXLo) && touch_x_i <= W'(tbd_pkg::UdXHi) &&
                     touch_y_i >= W'(tbd_pkg::UdYLo) && touch_y_i <= W'(tbd_pkg::UdYHi);
  assign in_up     = touch_y_i <= W'(tbd_pkg::UpYHi);
  assign in_down   = touch_y_i >= W'(tbd_pkg::DownYLo);
  assign in_lr_bar = touch_x_i <= W'(tbd_pkg::LrXHi) && touch_y_i <= W'(tbd_pkg::LrYHi);
  assign in_left   = touch_x_i <= W'(tbd_pkg::LeftXHi);
  assign in_right  = touch_x_i >= W'(tbd_pkg::RightXLo);

  // Cells do not overlap each other, so each compare stands alone.
  always_comb begin
    for (int unsigned i = 0; i < GridSections; i++) begin
      cell_hit[i] =
        touch_x_i >= tbd_pkg::cell_x_lo(i) &&
        touch_x_i <= tbd_pkg::cell_x_lo(i) + W'(tbd_pkg::CellSpanX) &&
        touch_y_i >= tbd_pkg::cell_y_lo(i) &&
        touch_y_i <= tbd_pkg::cell_y_lo(i) + W'(tbd_pkg::CellSpanY);
    end
  end

  // Lowest index wins: scan from the top down.
  always_comb begin
    any_cell = 1'b0;
    cell_idx = '0;
    for (int i = GridSections - 1; i >= 0; i--) begin
      if (cell_hit[i]) begin
        any_cell = 1'b1;
        cell_idx = tbd_pkg::SectW'(i);
      end
    end
  end

  always_comb begin
    hit_o.button  = tbd_pkg::BtnNone;
    hit_o.section = cell_idx;
    if (touch_pressed_i) begin
      if (in_ud_bar) begin
        if (in_up) begin
          hit_o.button = tbd_pkg::BtnUp;
        end else if (in_down) begin
          hit_o.button = tbd_pkg::BtnDown;
        end
      end else if (in_lr_bar) begin
        if (in_left) begin
          hit_o.button = tbd_pkg::BtnLeft;
        end else if (in_right) begin
          hit_o.button = tbd_pkg::BtnRight;
        end
      end else if (any_cell) begin
        hit_o.button = tbd_pkg::BtnSection;
      end
    end
  end

endmodule

// File: sv/touch_button_decoder.sv
// Top level of the touch button decoder: input register, decode and result register.
// Depends on tbd_pkg, the tbd_in_if/tbd_out_if interfaces and tbd_hit_test.
//
// Usage:
//   item_i carries one transaction per command: command 0 polls the panel (touch_x,
//   touch_y, touch_pressed, now_ms) and answers with an up/down step; command 1
//   reads one left/right tick; command 2 reads one key index. Every transaction
//   yields exactly one result transaction on result_o; fields that do not belong
//   to the command hold their none values (0, 0, -1).
//   The configuration port writes repeat_timeout_ms, accel_timeout_ms and
//   accel_step by index; write it only while no transaction is in flight.
// Pipeline and throughput:
//   A transaction is captured in the input register at its accept edge, decoded
//   combinationally from it and written into the result register at the first edge
//   on which that register is empty or drained, which raises result_o.valid.
//   One transaction per cycle is sustained while result_o takes results; the
//   critical path is the hit-test compares followed by the 32-bit held-time
//   subtract and timeout compares.
// Reset:
//   Both stages empty, registers at 250/1000/10, no button held, key -1.
// Stalls:
//   A stalled result holds in the result register; the input register keeps one
//   transaction behind it, then item_i.ready drops until result_o drains.
module touch_button_decoder #(
  parameter int unsigned GridSections = tbd_pkg::GridSectionsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tbd_in_if.sink                       item_i,
  tbd_out_if.source                    result_o,
  input  logic                         cfg_we_i,
  input  logic [tbd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tbd_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned TimeW = tbd_pkg::TimeW;

  // Configuration registers
  logic [tbd_pkg::TimeoutW-1:0] repeat_timeout_q, accel_timeout_q;
  logic [tbd_pkg::StepW-1:0]    accel_step_q;

  // Input register
  logic                        s1_valid_q;
  tbd_pkg::command_e           s1_cmd_q;
  logic [tbd_pkg::CoordW-1:0]  s1_x_q, s1_y_q;
  logic                        s1_pressed_q;
  logic [TimeW-1:0]            s1_now_q;

  // Decoder state
  tbd_pkg::button_e                btn_q, btn_d;
  logic signed [tbd_pkg::KeyW-1:0] section_q, section_d;
  logic                            tick_q, tick_d;
  logic [TimeW-1:0]                start_q, start_d;
  logic                            press_valid_q, press_valid_d;

  // Result register
  logic                            out_valid_q;
  logic signed [tbd_pkg::UdW-1:0]  ud_q, ud_d;
  logic signed [tbd_pkg::LrW-1:0]  lr_q, lr_d;
  logic signed [tbd_pkg::KeyW-1:0] key_q, key_d;

  logic                out_adv, s1_fire, in_fire;
  tbd_pkg::hit_t       hit;
  logic                new_start, tick_mid, is_step_btn, hold_off;
  logic [TimeW-1:0]    held;
  logic [tbd_pkg::UdW-1:0] mag;

  // Handshake: the result register frees a slot whenever it is empty or drained.
  assign out_adv      = !out_valid_q || result_o.ready;
  assign s1_fire      = s1_valid_q && out_adv;
  assign item_i.ready = !s1_valid_q || out_adv;
  assign in_fire      = item_i.valid && item_i.ready;

  assign result_o.valid          = out_valid_q;
  assign result_o.updown_step    = ud_q;
  assign result_o.leftright_step = lr_q;
  assign result_o.key_index      = key_q;

  // Configuration writes; the reserved index is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_timeout_q <= tbd_pkg::RepeatTimeoutRst;
      accel_timeout_q  <= tbd_pkg::AccelTimeoutRst;
      accel_step_q     <= tbd_pkg::AccelStepRst;
    end else if (cfg_we_i) begin
      case (tbd_pkg::cfg_reg_e'(cfg_idx_i))
        tbd_pkg::RegRepeatTimeout: repeat_timeout_q <= cfg_data_i;
        tbd_pkg::RegAccelTimeout:  accel_timeout_q  <= cfg_data_i;
        tbd_pkg::RegAccelStep:     accel_step_q     <= cfg_data_i[tbd_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: hold the transaction until the decode stage takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q     <= tbd_pkg::command_e'(item_i.command);
      s1_x_q       <= item_i.touch_x;
      s1_y_q       <= item_i.touch_y;
      s1_pressed_q <= item_i.touch_pressed;
      s1_now_q     <= item_i.now_ms;
    end
  end

  tbd_hit_test #(
    .GridSections(GridSections)
  ) u_hit_test (
    .touch_x_i      (s1_x_q),
    .touch_y_i      (s1_y_q),
    .touch_pressed_i(s1_pressed_q),
    .hit_o          (hit)
  );

  // Press timing for a poll: a new press starts the clock at now, so held is zero.
  assign new_start   = s1_pressed_q && hit.button != tbd_pkg::BtnNone && !press_valid_q;
  assign tick_mid    = s1_pressed_q && tick_q;
  assign held        = new_start ? '0 : s1_now_q - start_q;
  assign is_step_btn = hit.button == tbd_pkg::BtnUp || hit.button == tbd_pkg::BtnDown;
  assign hold_off    = tick_mid && held < TimeW'(repeat_timeout_q);
  assign mag         = (held > TimeW'(accel_timeout_q)) ? tbd_pkg::UdW'(accel_step_q)
                                                        : tbd_pkg::UdW'(1);

  always_comb begin
    btn_d         = btn_q;
    section_d     = section_q;
    tick_d        = tick_q;
    start_d       = start_q;
    press_valid_d = press_valid_q;
    ud_d          = '0;
    lr_d          = '0;
    key_d         = '1;
    case (s1_cmd_q)
      tbd_pkg::CmdPoll: begin
        btn_d  = hit.button;
        tick_d = tick_mid;
        if (hit.button == tbd_pkg::BtnSection) begin
          section_d = signed'(tbd_pkg::KeyW'(hit.section));
        end
        if (!s1_pressed_q) begin
          press_valid_d = 1'b0;
          start_d       = '0;
        end else if (new_start) begin
          press_valid_d = 1'b1;
          start_d       = s1_now_q;
        end
        // Emit a step unless a tick went out and the repeat delay has not passed.
        if (is_step_btn && !hold_off) begin
          tick_d = 1'b1;
          ud_d   = (hit.button == tbd_pkg::BtnDown) ? signed'(-mag) : signed'(mag);
        end
      end
      tbd_pkg::CmdReadLr: begin
        if ((btn_q == tbd_pkg::BtnLeft || btn_q == tbd_pkg::BtnRight) && !tick_q) begin
          tick_d = 1'b1;
          lr_d   = (btn_q == tbd_pkg::BtnLeft) ? '1 : tbd_pkg::LrW'(1);
        end
      end
      tbd_pkg::CmdReadKey: begin
        if (btn_q == tbd_pkg::BtnSection && !tick_q) begin
          tick_d = 1'b1;
          key_d  = section_q;
        end
      end
      default: ;
    endcase
  end

  // Advance decoder state once per decoded transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      btn_q         <= tbd_pkg::BtnNone;
      section_q     <= '1;
      tick_q        <= 1'b0;
      start_q       <= '0;
      press_valid_q <= 1'b0;
    end else if (s1_fire) begin
      btn_q         <= btn_d;
      section_q     <= section_d;
      tick_q        <= tick_d;
      start_q       <= start_d;
      press_valid_q <= press_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      ud_q  <= ud_d;
      lr_q  <= lr_d;
      key_q <= key_d;
    end
  end

  // A held up/down button always has a recorded press start.
  a_step_btn_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (btn_q == tbd_pkg::BtnUp || btn_q == tbd_pkg::BtnDown) |-> press_valid_q)
    else $error("up/down button held without a press start");

  // A released-panel poll clears the sent tick and the press.
  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_cmd_q == tbd_pkg::CmdPoll && !s1_pressed_q)
      |=> (!tick_q && !press_valid_q && btn_q == tbd_pkg::BtnNone))
    else $error("release poll left press state behind");

  // A waiting input transaction is not lost or altered while the result stalls.
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_adv) |=> (s1_valid_q && $stable(s1_now_q) && $stable(s1_cmd_q)))
    else $error("input register changed under a stall");

  // At most one field of a result carries an event.
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($countones({ud_q != '0, lr_q != '0, key_q != '1}) <= 1))
    else $error("result carries more than one event");

  // A reported key is always inside the configured grid.
  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && key_q != '1) |-> (key_q >= 0 && int'(key_q) < int'(GridSections)))
    else $error("key index outside the grid");

endmodule

// File: tb/touch_button_decoder_tb.sv
// Self-checking testbench for touch_button_decoder: randomized touch sessions and reads
// checked against a predictor of the button state. Depends on tbd_pkg, tbd_if and the RTL.
module touch_button_decoder_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned IdlePct    = 17;
  localparam int unsigned DrainWait  = 8;

  typedef struct {
    tbd_pkg::command_e          command;
    logic [tbd_pkg::CoordW-1:0] touch_x;
    logic [tbd_pkg::CoordW-1:0] touch_y;
    logic                       touch_pressed;
    logic [tbd_pkg::TimeW-1:0]  now_ms;
  } touch_item_t;

  typedef struct packed {
    logic [tbd_pkg::UdW-1:0]  updown_step;
    logic [tbd_pkg::LrW-1:0]  leftright_step;
    logic [tbd_pkg::KeyW-1:0] key_index;
  } button_event_t;

  // Clock, reset and configuration port; initialized so nothing is X at time zero.
  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         cfg_we     = 1'b0;
  logic [tbd_pkg::CfgIdxW-1:0]  cfg_idx    = '0;
  logic [tbd_pkg::CfgDataW-1:0] cfg_data   = '0;
  logic                         drv_valid  = 1'b0;
  touch_item_t                  drv_item   = '{tbd_pkg::CmdPoll, '0, '0, 1'b0, '0};
  logic                         sink_ready = 1'b0;
  logic                         in_taken   = 1'b0;
  bit                           stall_en   = 1'b1;

  tbd_in_if  in_if ();
  tbd_out_if out_if ();

  assign in_if.valid         = drv_valid;
  assign in_if.command       = drv_item.command;
  assign in_if.touch_x       = drv_item.touch_x;
  assign in_if.touch_y       = drv_item.touch_y;
  assign in_if.touch_pressed = drv_item.touch_pressed;
  assign in_if.now_ms        = drv_item.now_ms;
  assign out_if.ready        = sink_ready;

  touch_button_decoder uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .item_i     (in_if),
    .result_o   (out_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  touch_item_t   touch_items[$];
  button_event_t awaited_events[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;
  logic [tbd_pkg::TimeW-1:0] clock_ms = '0;

  // Predicted decoder state and register copies, at their reset values.
  tbd_pkg::button_e          held_button  = tbd_pkg::BtnNone;
  logic [tbd_pkg::KeyW-1:0]  last_section = '1;
  logic                      tick_given   = 1'b0;
  logic [tbd_pkg::TimeW-1:0] press_start  = '0;
  logic                      press_active = 1'b0;
  logic [15:0]               repeat_ms    = 16'd250;
  logic [15:0]               accel_ms     = 16'd1000;
  logic [6:0]                big_step     = 7'd10;

  // Advance the predicted state by one accepted transaction and build its event.
  task automatic decode_touch_item(input touch_item_t it, output button_event_t ev);
    int unsigned               px, py, cx, cy;
    logic [tbd_pkg::TimeW-1:0] held;
    logic [tbd_pkg::UdW-1:0]   mag;
    logic                      found;
    ev.updown_step    = '0;
    ev.leftright_step = '0;
    ev.key_index      = '1;
    px = it.touch_x;
    py = it.touch_y;
    case (it.command)
      tbd_pkg::CmdPoll: begin
        held_button = tbd_pkg::BtnNone;
        if (it.touch_pressed) begin
          if (px >= 300 && px <= 319 && py >= 17 && py <= 239) begin
            // Up/down bar: only its two end zones are buttons.
            if (py <= 37) begin
              held_button = tbd_pkg::BtnUp;
            end else if (py >= 219) begin
              held_button = tbd_pkg::BtnDown;
            end
          end else if (px <= 295 && py <= 17) begin
            if (px <= 15) begin
              held_button = tbd_pkg::BtnLeft;
            end else if (px >= 280) begin
              held_button = tbd_pkg::BtnRight;
            end
          end else begin
            // Grid: the lowest matching section wins; keep the old index on a miss.
            found = 1'b0;
            for (int i = 0; i < 16; i++) begin
              cx = (i % 4) * 75;
              cy = 30 + (i / 4) * 45;
              if (!found && px >= cx && px <= cx + 70 && py >= cy && py <= cy + 40) begin
                found        = 1'b1;
                held_button  = tbd_pkg::BtnSection;
                last_section = tbd_pkg::KeyW'(i);
              end
            end
          end
        end
        // Release clears the press; a miss while pressed keeps the press timing.
        if (!it.touch_pressed) begin
          press_active = 1'b0;
          press_start  = '0;
          tick_given   = 1'b0;
        end else if (held_button != tbd_pkg::BtnNone && !press_active) begin
          press_active = 1'b1;
          press_start  = it.now_ms;
        end
        if (held_button == tbd_pkg::BtnUp || held_button == tbd_pkg::BtnDown) begin
          held = it.now_ms - press_start;
          if (!(tick_given && held < {16'd0, repeat_ms})) begin
            mag            = (held > {16'd0, accel_ms}) ? {1'b0, big_step} : 8'd1;
            tick_given     = 1'b1;
            ev.updown_step = (held_button == tbd_pkg::BtnDown) ? -mag : mag;
          end
        end
      end
      tbd_pkg::CmdReadLr: begin
        if ((held_button == tbd_pkg::BtnLeft || held_button == tbd_pkg::BtnRight) &&
            !tick_given) begin
          tick_given        = 1'b1;
          ev.leftright_step = (held_button == tbd_pkg::BtnLeft) ? 2'b11 : 2'b01;
        end
      end
      tbd_pkg::CmdReadKey: begin
        if (held_button == tbd_pkg::BtnSection && !tick_given) begin
          tick_given   = 1'b1;
          ev.key_index = last_section;
        end
      end
      default: begin
      end
    endcase
  endtask

  // Driver: present a new transaction after the previous one was taken, or idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_taken) begin
      if (touch_items.size() > 0 && !(stall_en && $urandom_range(0, 99) < IdlePct)) begin
        drv_item  <= touch_items.pop_front();
        drv_valid <= 1'b1;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // Sink: stall the result channel at random.
  always @(negedge clk) begin
    sink_ready <= !stall_en || ($urandom_range(0, 99) >= IdlePct);
  end

  // Monitor: check the delivered event first, then predict for the accepted input.
  always @(posedge clk) begin : monitor
    touch_item_t   accepted;
    button_event_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) begin
        if (awaited_events.size() == 0) begin
          $display("%0t: result transaction with none expected: ud %0d lr %0d key %0d",
                   $time, out_if.updown_step, out_if.leftright_step, out_if.key_index);
          mismatch_count++;
        end else begin
          want = awaited_events.pop_front();
          if (out_if.updown_step !== want.updown_step) begin
            $display("%0t: updown_step expected %0d actual %0d", $time,
                     $signed(want.updown_step), out_if.updown_step);
            mismatch_count++;
          end
          if (out_if.leftright_step !== want.leftright_step) begin
            $display("%0t: leftright_step expected %0d actual %0d", $time,
                     $signed(want.leftright_step), out_if.leftright_step);
            mismatch_count++;
          end
          if (out_if.key_index !== want.key_index) begin
            $display("%0t: key_index expected %0d actual %0d", $time,
                     $signed(want.key_index), out_if.key_index);
            mismatch_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        accepted = '{tbd_pkg::command_e'(in_if.command), in_if.touch_x, in_if.touch_y,
                     in_if.touch_pressed, in_if.now_ms};
        decode_touch_item(accepted, want);
        awaited_events.push_back(want);
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_item(input tbd_pkg::command_e c, input logic [tbd_pkg::CoordW-1:0] x,
                           input logic [tbd_pkg::CoordW-1:0] y, input logic p,
                           input logic [tbd_pkg::TimeW-1:0] t);
    touch_items.push_back('{c, x, y, p, t});
  endtask

  // Write one register at idle and mirror it into the predictor.
  task automatic write_reg(input tbd_pkg::cfg_reg_e idx,
                           input logic [tbd_pkg::CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tbd_pkg::RegRepeatTimeout: repeat_ms = val;
      tbd_pkg::RegAccelTimeout:  accel_ms  = val;
      tbd_pkg::RegAccelStep:     big_step  = val[6:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input logic [15:0] rep, input logic [15:0] acc,
                            input logic [6:0] step);
    write_reg(tbd_pkg::RegRepeatTimeout, rep);
    write_reg(tbd_pkg::RegAccelTimeout, acc);
    write_reg(tbd_pkg::RegAccelStep, {9'd0, step});
  endtask

  // Hold until the driver queue is empty and every expected event has arrived.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (touch_items.size() != 0 || in_if.valid || awaited_events.size() != 0);
  endtask

  // Pick a touch point inside the given button, or somewhere that hits nothing.
  task automatic pick_point(input tbd_pkg::button_e b, input int unsigned s,
                            output logic [tbd_pkg::CoordW-1:0] x,
                            output logic [tbd_pkg::CoordW-1:0] y);
    int unsigned col, row;
    col = s % 4;
    row = s / 4;
    case (b)
      tbd_pkg::BtnUp: begin
        x = 9'($urandom_range(300, 319));
        y = 9'($urandom_range(17, 37));
      end
      tbd_pkg::BtnDown: begin
        x = 9'($urandom_range(300, 319));
        y = 9'($urandom_range(219, 239));
      end
      tbd_pkg::BtnLeft: begin
        x = 9'($urandom_range(0, 15));
        y = 9'($urandom_range(0, 17));
      end
      tbd_pkg::BtnRight: begin
        x = 9'($urandom_range(280, 295));
        y = 9'($urandom_range(0, 17));
      end
      tbd_pkg::BtnSection: begin
        x = 9'(col * 75 + $urandom_range(0, 70));
        y = 9'(30 + row * 45 + $urandom_range(0, 40));
      end
      default: begin
        case ($urandom_range(0, 4))
          0: begin  // middle of the up/down bar
            x = 9'($urandom_range(300, 319));
            y = 9'($urandom_range(38, 218));
          end
          1: begin  // middle of the left/right bar
            x = 9'($urandom_range(16, 279));
            y = 9'($urandom_range(0, 17));
          end
          2: begin  // strip between panel and up/down bar
            x = 9'($urandom_range(296, 299));
            y = 9'($urandom_range(0, 511));
          end
          3: begin  // off screen to the right
            x = 9'($urandom_range(320, 511));
            y = 9'($urandom_range(0, 511));
          end
          default: begin  // gaps between grid columns
            x = 9'($urandom_range(0, 2) * 75 + $urandom_range(71, 74));
            y = 9'($urandom_range(30, 205));
          end
        endcase
      end
    endcase
  endtask

  // Time between polls: short, around the repeat timeout, long, or up to past any timeout.
  function automatic logic [tbd_pkg::TimeW-1:0] next_gap();
    case ($urandom_range(0, 3))
      0:       return tbd_pkg::TimeW'($urandom_range(0, 40));
      1:       return {16'd0, repeat_ms} + tbd_pkg::TimeW'($urandom_range(0, 2)) - 1;
      2:       return tbd_pkg::TimeW'($urandom_range(0, 1200));
      default: return tbd_pkg::TimeW'($urandom_range(0, 70000));
    endcase
  endfunction

  // One press: polls on a target (sliding now and then), reads in between, release.
  task automatic gen_session(inout int unsigned made);
    tbd_pkg::button_e           target;
    int unsigned                sect, polls;
    logic [tbd_pkg::CoordW-1:0] x, y;
    target = tbd_pkg::button_e'($urandom_range(0, 5));
    sect   = $urandom_range(0, 15);
    polls  = $urandom_range(1, 8);
    if ($urandom_range(0, 9) == 0) begin
      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    end else if ($urandom_range(0, 9) == 0) begin
      clock_ms = $urandom();
    end
    for (int k = 0; k < polls; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        target = tbd_pkg::button_e'($urandom_range(0, 5));
        sect   = $urandom_range(0, 15);
      end
      pick_point(target, sect, x, y);
      clock_ms += next_gap();
      push_item(tbd_pkg::CmdPoll, x, y, 1'b1, clock_ms);
      made++;
      repeat ($urandom_range(0, 2)) begin
        push_item(tbd_pkg::command_e'($urandom_range(1, 2)), 9'($urandom()),
                  9'($urandom()), 1'($urandom()), $urandom());
        made++;
      end
    end
    if ($urandom_range(0, 4) != 0) begin
      clock_ms += next_gap();
      push_item(tbd_pkg::CmdPoll, 9'($urandom()), 9'($urandom()), 1'b0, clock_ms);
      made++;
    end
  endtask

  // Fill the queue with sessions plus raw noise, then drain.
  task automatic run_random(input int unsigned count);
    int unsigned made;
    made = 0;
    @(posedge clk);
    while (made < count) begin
      if ($urandom_range(0, 99) < 15) begin
        push_item(tbd_pkg::command_e'($urandom_range(0, 3)), 9'($urandom()),
                  9'($urandom()), 1'($urandom()), $urandom());
        made++;
      end else begin
        gen_session(made);
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed pass at reset register values (250 / 1000 / 10).
    @(posedge clk);
    push_item(tbd_pkg::CmdUnused, 9'd511, 9'd511, 1'b1, 32'hFFFF_FFFF);
    push_item(tbd_pkg::CmdReadLr, 9'd0, 9'd0, 1'b0, 32'd0);
    push_item(tbd_pkg::CmdReadKey, 9'd0, 9'd0, 1'b0, 32'd0);
    // Hold up from time zero: first tick, blocked, repeat at the edge, accelerate.
    push_item(tbd_pkg::CmdPoll, 9'd300, 9'd17, 1'b1, 32'd0);
    push_item(tbd_pkg::CmdPoll, 9'd319, 9'd37, 1'b1, 32'd100);
    push_item(tbd_pkg::CmdPoll, 9'd310, 9'd20, 1'b1, 32'd250);
    push_item(tbd_pkg::CmdPoll, 9'd511, 9'd511, 1'b1, 32'd400);
    push_item(tbd_pkg::CmdPoll, 9'd305, 9'd30, 1'b1, 32'd1001);
    push_item(tbd_pkg::CmdPoll, 9'd0, 9'd0, 1'b0, 32'd1100);
    // Hold down across the time wrap.
    push_item(tbd_pkg::CmdPoll, 9'd319, 9'd239, 1'b1, 32'hFFFF_FF00);
    push_item(tbd_pkg::CmdPoll, 9'd300, 9'd219, 1'b1, 32'h0000_0400);
    push_item(tbd_pkg::CmdPoll, 9'd310, 9'd100, 1'b1, 32'h0000_0500);
    push_item(tbd_pkg::CmdPoll, 9'd200, 9'd200, 1'b0, 32'h0000_0600);
    // Left and right: one tick per press.
    push_item(tbd_pkg::CmdPoll, 9'd0, 9'd0, 1'b1, 32'd5000);
    push_item(tbd_pkg::CmdReadLr, 9'd0, 9'd0, 1'b0, 32'd0);
    push_item(tbd_pkg::CmdReadLr, 9'd0, 9'd0, 1'b0, 32'd0);
    push_item(tbd_pkg::CmdPoll, 9'd0, 9'd0, 1'b0, 32'd5100);
    push_item(tbd_pkg::CmdPoll, 9'd295, 9'd17, 1'b1, 32'd6000);
    push_item(tbd_pkg::CmdReadLr, 9'd0, 9'd0, 1'b0, 32'd0);
    push_item(tbd_pkg::CmdReadKey, 9'd0, 9'd0, 1'b0, 32'd0);
    push_item(tbd_pkg::CmdPoll, 9'd0, 9'd0, 1'b0, 32'd6100);
    // Sections: corner cells, then a slide within the same press.
    push_item(tbd_pkg::CmdPoll, 9'd295, 9'd205, 1'b1, 32'd7000);
    push_item(tbd_pkg::CmdReadKey, 9'd0, 9'd0, 1'b0, 32'd0);
    push_item(tbd_pkg::CmdReadKey, 9'd0, 9'd0, 1'b0, 32'd0);
    push_item(tbd_pkg::CmdPoll, 9'd0, 9'd30, 1'b1, 32'd7100);
    push_item(tbd_pkg::CmdReadKey, 9'd0, 9'd0, 1'b0, 32'd0);
    push_item(tbd_pkg::CmdPoll, 9'd296, 9'd18, 1'b0, 32'd7200);
    wait_drained();
    run_random(90);

    // Lowest timeouts, top step, no idling on either side.
    stall_en = 1'b0;
    set_config(16'd0, 16'd0, 7'd100);
    run_random(90);

    // Highest timeouts, smallest step.
    stall_en = 1'b1;
    set_config(16'hFFFF, 16'hFFFF, 7'd1);
    run_random(90);

    // Zero step still marks a tick as sent.
    set_config(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)), 7'd0);
    run_random(40);

    // Step beyond its nominal range, arbitrary timeouts.
    set_config(16'($urandom()), 16'($urandom_range(0, 3000)), 7'd127);
    run_random(40);

    repeat (DrainWait) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
